// File: sv/sha256_pkg.sv
// package with shared types, constants and round functions for the sha-256 hasher
`timescale 1ns / 1ps

package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
        logic       carries_no_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // command handed from the front part to the compression engine
    typedef enum logic [1:0] {
        CMD_BLOCK  = 2'd0,  // compress, keep chaining
        CMD_FINAL  = 2'd1,  // compress, then emit digest and reinit
        CMD_DIGEST = 2'd2   // unused slot; the engine would treat it as CMD_BLOCK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t     kind;
        logic [511:0]  block;
    } blk_cmd_t;

    typedef enum logic [1:0] {
        FE_COLLECT = 2'd0,
        FE_PAD1    = 2'd1,
        FE_PAD2    = 2'd2
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE  = 2'd0,
        BE_ROUND = 2'd1,
        BE_ADD   = 2'd2,
        BE_EMIT  = 2'd3
    } be_state_t;

    localparam int COUNT_W = 61;
    localparam int QDEPTH  = 2;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: sv/sha256_front.sv
// front part: packs bytes into blocks, counts length and builds padding blocks
`timescale 1ns / 1ps

module sha256_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha256_pkg::in_item_t s_item,
    input  logic                 s_valid,
    output logic                 s_ready,
    output sha256_pkg::blk_cmd_t cmd,
    output logic                 cmd_valid,
    input  logic                 cmd_ready
);

    sha256_pkg::fe_state_t state_reg, state_next;
    logic [511:0]                 buf_reg, buf_next;
    logic [sha256_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [63:0]                  bits;
    logic [5:0]                   pos;
    logic [5:0]                   new_pos;
    logic                         take;
    logic                         has_byte;
    logic [511:0]                 byte_buf;
    logic [511:0]                 pad_buf;
    logic [sha256_pkg::COUNT_W-1:0] cnt_after;

    assign take     = s_valid && s_ready;
    assign has_byte = !s_item.carries_no_byte;
    assign pos      = count_reg[5:0];
    assign cnt_after = has_byte ? count_reg + 1'b1 : count_reg;
    assign new_pos  = cnt_after[5:0];
    assign bits     = {count_reg[60:0], 3'b000};

    // buffer with the incoming byte inserted at its position
    always_comb begin
        byte_buf = buf_reg;
        byte_buf[511 - {pos, 3'b000} -: 8] = s_item.data_byte;
    end

    // buffer with 0x80 and zeros from the current position on
    always_comb begin
        pad_buf = buf_reg;
        for (int i = 0; i < 64; i++) begin
            if (i[5:0] == pos) begin
                pad_buf[511 - 8*i -: 8] = 8'h80;
            end else if (i[5:0] > pos) begin
                pad_buf[511 - 8*i -: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::FE_COLLECT: begin
                if (take && s_item.end_of_message && !(has_byte && new_pos == 6'd0)) begin
                    state_next = sha256_pkg::FE_PAD1;
                end else if (take && s_item.end_of_message) begin
                    state_next = sha256_pkg::FE_PAD1;
                end
            end
            sha256_pkg::FE_PAD1: begin
                if (cmd_ready) begin
                    state_next = (pos >= 6'd56) ? sha256_pkg::FE_PAD2
                                                : sha256_pkg::FE_COLLECT;
                end
            end
            sha256_pkg::FE_PAD2: begin
                if (cmd_ready) begin
                    state_next = sha256_pkg::FE_COLLECT;
                end
            end
            default: state_next = sha256_pkg::FE_COLLECT;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd_valid  = 1'b0;
        cmd.kind   = sha256_pkg::CMD_BLOCK;
        cmd.block  = byte_buf;
        buf_next   = buf_reg;
        count_next = count_reg;
        unique case (state_reg)
            sha256_pkg::FE_COLLECT: begin
                // a byte that fills the block needs the queue
                s_ready   = !(has_byte && pos == 6'd63) || cmd_ready;
                cmd_valid = s_valid && has_byte && pos == 6'd63;
                if (take) begin
                    count_next = cnt_after;
                    if (has_byte) begin
                        buf_next = byte_buf;
                    end
                end
            end
            sha256_pkg::FE_PAD1: begin
                cmd_valid = 1'b1;
                if (pos >= 6'd56) begin
                    cmd.block = pad_buf;
                    cmd.kind  = sha256_pkg::CMD_BLOCK;
                end else begin
                    cmd.block = {pad_buf[511:64], bits};
                    cmd.kind  = sha256_pkg::CMD_FINAL;
                end
                if (cmd_ready && pos < 6'd56) begin
                    count_next = '0;
                end
            end
            sha256_pkg::FE_PAD2: begin
                cmd_valid = 1'b1;
                cmd.block = {448'd0, bits};
                cmd.kind  = sha256_pkg::CMD_FINAL;
                if (cmd_ready) begin
                    count_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha256_pkg::FE_COLLECT;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        buf_reg <= buf_next;
    end

endmodule

// File: sv/sha256_queue.sv
// short queue of block commands between the front part and the engine
`timescale 1ns / 1ps

module sha256_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha256_pkg::blk_cmd_t wr_cmd,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    output sha256_pkg::blk_cmd_t rd_cmd,
    output logic                 rd_valid,
    input  logic                 rd_ready
);

    sha256_pkg::blk_cmd_t slot_reg [sha256_pkg::QDEPTH];
    logic [$clog2(sha256_pkg::QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(sha256_pkg::QDEPTH):0]   cnt_reg;
    logic push, pop;

    assign wr_ready = cnt_reg != sha256_pkg::QDEPTH[$clog2(sha256_pkg::QDEPTH):0];
    assign rd_valid = cnt_reg != '0;
    assign rd_cmd   = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{$clog2(sha256_pkg::QDEPTH){1'b0}}, push}
                               - {{$clog2(sha256_pkg::QDEPTH){1'b0}}, pop};
        end
        if (push) slot_reg[wp_reg] <= wr_cmd;
    end

endmodule

// File: sv/sha256_engine.sv
// back part: 64-round compression, one round per cycle, and digest output
`timescale 1ns / 1ps

module sha256_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha256_pkg::blk_cmd_t  cmd,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    output sha256_pkg::out_item_t m_item,
    output logic                  m_valid,
    input  logic                  m_ready
);

    sha256_pkg::be_state_t state_reg, state_next;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [5:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        final_reg;
    logic [31:0] w_new, t1, t2, e, a;
    logic        load;

    assign load = (state_reg == sha256_pkg::BE_IDLE) && cmd_valid;
    assign e = v_reg[4];
    assign a = v_reg[0];
    assign t1 = v_reg[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
              ^ sha256_pkg::rotr(e, 25)) + ((e & v_reg[5]) ^ (~e & v_reg[6]))
              + sha256_pkg::round_k(rnd_reg) + w_reg[0];
    assign t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13)
              ^ sha256_pkg::rotr(a, 22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = w_reg[0]
                 + (sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18)
                    ^ (w_reg[1] >> 3))
                 + w_reg[9]
                 + (sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
                    ^ (w_reg[14] >> 10));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::BE_IDLE:  if (cmd_valid) state_next = sha256_pkg::BE_ROUND;
            sha256_pkg::BE_ROUND: if (rnd_reg == 6'd63) state_next = sha256_pkg::BE_ADD;
            sha256_pkg::BE_ADD:   state_next = final_reg ? sha256_pkg::BE_EMIT
                                                         : sha256_pkg::BE_IDLE;
            sha256_pkg::BE_EMIT:  if (m_ready && idx_reg == 3'd7)
                                      state_next = sha256_pkg::BE_IDLE;
            default: state_next = sha256_pkg::BE_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready          = state_reg == sha256_pkg::BE_IDLE;
        m_valid            = state_reg == sha256_pkg::BE_EMIT;
        m_item.digest_word = h_reg[idx_reg];
        m_item.word_index  = idx_reg;
        m_item.last_word   = idx_reg == 3'd7;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha256_pkg::BE_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            final_reg <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha256_pkg::INIT_HASH[255 - 32*i -: 32];
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                sha256_pkg::BE_IDLE: begin
                    rnd_reg   <= '0;
                    final_reg <= cmd.kind == sha256_pkg::CMD_FINAL;
                end
                sha256_pkg::BE_ROUND: rnd_reg <= rnd_reg + 1'b1;
                sha256_pkg::BE_ADD: begin
                    idx_reg <= '0;
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                end
                sha256_pkg::BE_EMIT: begin
                    if (m_ready) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= sha256_pkg::INIT_HASH[255 - 32*i -: 32];
                        end
                    end
                end
                default: ;
            endcase
        end
        if (load) begin
            for (int i = 0; i < 16; i++) w_reg[i] <= cmd.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++)  v_reg[i] <= h_reg[i];
        end else if (state_reg == sha256_pkg::BE_ROUND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

// File: sv/sha256_message_hasher.sv
// top level of the sha-256 byte-stream hasher
`timescale 1ns / 1ps

// channel   | direction | transfer carries
// s_ (in)   | input     | one message byte, end flag, no-byte flag
// m_ (out)  | output    | one digest word, its index, last-word flag
//
// bytes are taken one per cycle, but not while padding blocks go out; the
// 64th byte of a block waits for a free slot in the 2-entry queue. the
// engine takes a block only when idle and runs 64 rounds and the add
// before the next. the end of a message adds one or two padding blocks,
// then eight output transfers. reset (aresetn low, synchronous) restores
// the initial hash and a zero count. either side may stall without loss.

module sha256_message_hasher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha256_pkg::in_item_t  s_item,
    input  logic                  s_valid,
    output logic                  s_ready,
    output sha256_pkg::out_item_t m_item,
    output logic                  m_valid,
    input  logic                  m_ready
);

    sha256_pkg::blk_cmd_t fe_cmd, q_cmd;
    logic fe_valid, fe_ready, q_valid, q_ready;

    // front part: byte packing and padding
    sha256_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cmd       (fe_cmd),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready)
    );

    // block queue decouples the two parts
    sha256_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_cmd   (fe_cmd),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .rd_cmd   (q_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    // compression engine and digest output
    sha256_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .m_item    (m_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule
